[design/rcpm_pkg.sv]
package rcpm_pkg;

  // configuration register indexes
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_LOG2  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_MIDI_CHANNEL = 1'b1;

  localparam logic [3:0] WINDOW_LOG2_RESET  = 4'd14;
  localparam logic [3:0] MIDI_CHANNEL_RESET = 4'd0;

  localparam logic [6:0] NO_PITCH_NOTE = 7'd60;
  localparam logic [6:0] VELOCITY_BASE = 7'd64;
  localparam int unsigned REF_NOTE  = 69;
  localparam int unsigned SEMITONES = 12;

  // log2(8000/440) in Q30
  localparam longint unsigned RATE_RATIO_LOG2_Q30 = 64'd4492991702;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_SQUARE,
    ST_CALC_S,
    ST_CALC_T,
    ST_CALC_ABS,
    ST_CALC_NOTE,
    ST_WRITE
  } rcpm_state_t;

  typedef struct packed {
    logic accept;
    logic norm_step;
    logic sq_step;
    logic calc_s;
    logic calc_t;
    logic calc_abs;
    logic calc_note;
    logic out_load;
  } rcpm_cmd_t;

  typedef struct packed {
    logic win_end;
    logic multi_run;
    logic norm_done;
    logic sq_last;
    logic out_free;
  } rcpm_sts_t;

endpackage

[design/rcpm_ctrl.sv]
module rcpm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  rcpm_pkg::rcpm_sts_t sts,
  output rcpm_pkg::rcpm_cmd_t cmd
);
  import rcpm_pkg::*;

  rcpm_state_t state;
  rcpm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid && sts.win_end) begin
          state_next = sts.multi_run ? ST_NORM : ST_WRITE;
        end
      end
      ST_NORM: begin
        cmd.norm_step = 1'b1;
        if (sts.norm_done) begin
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.sq_step = 1'b1;
        if (sts.sq_last) begin
          state_next = ST_CALC_S;
        end
      end
      ST_CALC_S: begin
        cmd.calc_s = 1'b1;
        state_next = ST_CALC_T;
      end
      ST_CALC_T: begin
        cmd.calc_t = 1'b1;
        state_next = ST_CALC_ABS;
      end
      ST_CALC_ABS: begin
        cmd.calc_abs = 1'b1;
        state_next   = ST_CALC_NOTE;
      end
      ST_CALC_NOTE: begin
        cmd.calc_note = 1'b1;
        state_next    = ST_WRITE;
      end
      ST_WRITE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[design/rcpm_dp.sv]
module rcpm_dp #(
  parameter int LOG_FRACTION_BITS = 16,
  parameter int MAX_WINDOW_LOG2   = 15
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [6:0]                          sample,
  input  logic                                cfg_we,
  input  logic [rcpm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [3:0]                          cfg_wdata,
  input  rcpm_pkg::rcpm_cmd_t                 cmd,
  output rcpm_pkg::rcpm_sts_t                 sts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [6:0]                          out_note,
  output logic [6:0]                          out_vel,
  output logic [3:0]                          out_chan
);
  import rcpm_pkg::*;

  localparam int F   = LOG_FRACTION_BITS;
  localparam int W   = MAX_WINDOW_LOG2;
  localparam int PW  = W + 1;              // position, holds 2^W
  localparam int RW  = W;                  // run count, at most 2^(W-1)
  localparam int KW  = $clog2(W + 1);
  localparam int PBW = $clog2(W);
  localparam int AW  = PBW + F;
  localparam int IW  = $clog2(F + 1);
  localparam int TW  = F + 11;
  localparam longint unsigned C_F =
    (RATE_RATIO_LOG2_Q30 + (64'd1 << (29 - F))) >> (30 - F);

  // config
  logic [3:0] window_log2;
  logic [3:0] midi_channel;

  // window counters
  logic [PW-1:0] pos;
  logic [RW-1:0] runs;
  logic          prev_zero;
  logic [6:0]    peak;

  // log datapath
  logic [RW-1:0]         nrm;
  logic [PBW-1:0]        lead;
  logic [31:0]           m;
  logic [AW-1:0]         acc;
  logic [IW-1:0]         iter;
  logic [KW-1:0]         k_hold;
  logic signed [TW-1:0]  tmp;
  logic                  neg;
  logic [6:0]            res_note;
  logic [6:0]            res_vel;

  logic [KW-1:0] k_eff;
  logic [6:0]    peak_next;
  logic          run_inc;
  logic [RW-1:0] runs_next;
  logic [PW-1:0] pos_next;
  logic [61:0]   sq;
  logic [31:0]   sq_q30;
  logic [6:0]    q7;

  always_comb begin
    k_eff     = (32'(window_log2) > 32'(W)) ? KW'(W) : KW'(window_log2);
    peak_next = (sample > peak) ? sample : peak;
    run_inc   = (sample != 7'd0) && prev_zero;
    runs_next = runs + RW'(run_inc);
    pos_next  = pos + PW'(1);
    sq        = 62'(m[30:0]) * 62'(m[30:0]);
    sq_q30    = sq[61:30];
    q7        = tmp[F+6:F];

    sts.win_end   = pos_next >= (PW'(1) << k_eff);
    sts.multi_run = runs_next > RW'(1);
    sts.norm_done = nrm[RW-1];
    sts.sq_last   = iter == IW'(F - 1);
    sts.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_log2  <= WINDOW_LOG2_RESET;
      midi_channel <= MIDI_CHANNEL_RESET;
      pos          <= '0;
      runs         <= '0;
      prev_zero    <= 1'b1;
      peak         <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_WINDOW_LOG2:  window_log2  <= cfg_wdata;
          REG_MIDI_CHANNEL: midi_channel <= cfg_wdata;
        endcase
      end
      if (cmd.accept) begin
        if (sts.win_end) begin
          pos       <= '0;
          runs      <= '0;
          prev_zero <= 1'b1;
          peak      <= '0;
        end else begin
          pos       <= pos_next;
          runs      <= runs_next;
          prev_zero <= (sample == 7'd0);
          peak      <= peak_next;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && sts.win_end) begin
      nrm      <= runs_next;
      lead     <= PBW'(W - 1);
      k_hold   <= k_eff;
      res_note <= NO_PITCH_NOTE;
      res_vel  <= sts.multi_run ? (VELOCITY_BASE + peak_next) : 7'd0;
    end
    // shift the run count up until its leading one reaches the top bit
    if (cmd.norm_step) begin
      if (nrm[RW-1]) begin
        m    <= 32'(nrm) << (31 - W);
        acc  <= AW'(lead);
        iter <= '0;
      end else begin
        nrm  <= nrm << 1;
        lead <= lead - PBW'(1);
      end
    end
    // one fraction bit per squaring of the Q30 mantissa
    if (cmd.sq_step) begin
      m    <= sq_q30[31] ? (sq_q30 >> 1) : sq_q30;
      acc  <= {acc[AW-2:0], sq_q30[31]};
      iter <= iter + IW'(1);
    end
    if (cmd.calc_s) begin
      tmp <= $signed(TW'(acc)) + $signed(TW'(C_F)) - $signed(TW'(k_hold) << F);
    end
    if (cmd.calc_t) begin
      tmp <= tmp * $signed(TW'(SEMITONES)) + $signed(TW'(REF_NOTE) << F);
    end
    // truncate toward zero: divide the magnitude, restore the sign
    if (cmd.calc_abs) begin
      neg <= tmp[TW-1];
      tmp <= tmp[TW-1] ? -tmp : tmp;
    end
    if (cmd.calc_note) begin
      res_note <= neg ? (7'd0 - q7) : q7;
    end
    if (cmd.out_load) begin
      out_note <= res_note;
      out_vel  <= res_vel;
      out_chan <= midi_channel;
    end
  end

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos < (PW'(1) << W))
    else $error("window position beyond maximum window");

  a_runs_bound: assert property (@(posedge clk) disable iff (rst)
    (PW'(runs) << 1) <= (PW'(pos) + PW'(1)))
    else $error("run count exceeds half the window position");

  a_norm_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.norm_step |-> (nrm != '0))
    else $error("normalizing a zero run count");

  a_mant_range: assert property (@(posedge clk) disable iff (rst)
    cmd.sq_step |-> (m[30] && !m[31]))
    else $error("mantissa outside [1,2)");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("result load did not raise valid");

endmodule

[design/run_count_pitch_to_midi_note.sv]
// Channel   Dir  Handshake          Payload
// s_axis    in   s_tvalid/s_tready  s_tdata[6:0] sample
// m_axis    out  m_tvalid/m_tready  m_tdata[17:0] note_number, velocity, channel
// cfg       in   cfg_we             cfg_addr index, cfg_wdata value
//
// Samples inside a window are taken one per cycle.
// A window end with more than one run goes through the normalize steps, one squaring
// per fraction bit (LOG_FRACTION_BITS in all), the S, T, ABS and NOTE arithmetic states
// and a load; with at most one run it goes straight to the load. No samples in between.
// Synchronous reset clears the window counters and m_tvalid and resets the config registers.
// One result waits in the output register while samples keep flowing; a second
// window end holds s_tready low until that result is taken.
module run_count_pitch_to_midi_note #(
  parameter int LOG_FRACTION_BITS = 16,
  parameter int MAX_WINDOW_LOG2   = 15
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [6:0] sample
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [23:0]                     m_tdata,   // [6:0] note_number, [13:7] velocity,
                                                     // [17:14] channel
  input  logic                            cfg_we,
  input  logic [rcpm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [3:0]                      cfg_wdata
);
  import rcpm_pkg::*;

  rcpm_cmd_t  cmd;
  rcpm_sts_t  sts;
  logic [6:0] out_note;
  logic [6:0] out_vel;
  logic [3:0] out_chan;

  rcpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rcpm_dp #(
    .LOG_FRACTION_BITS (LOG_FRACTION_BITS),
    .MAX_WINDOW_LOG2   (MAX_WINDOW_LOG2)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .sample    (s_tdata[6:0]),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_note  (out_note),
    .out_vel   (out_vel),
    .out_chan  (out_chan)
  );

  assign m_tdata = {6'd0, out_chan, out_vel, out_note};

endmodule

[sim/rcpm_note_checker.sv]
`timescale 1ns / 1ps
module rcpm_note_checker #(
  parameter int LOG_FRACTION_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [6:0] sample
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [23:0]                     m_tdata,   // [6:0] note_number, [13:7] velocity,
                                                     // [17:14] channel
  input  logic                            cfg_we,
  input  logic [rcpm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [3:0]                      cfg_wdata,
  output int                              fail_count,
  output int                              notes_pending
);
  import rcpm_pkg::*;

  typedef struct packed {
    logic [3:0] channel;
    logic [6:0] velocity;
    logic [6:0] note_number;
  } midi_note_t;

  midi_note_t  notes_due[$];
  logic [3:0]  window_log2;
  logic [3:0]  midi_channel;
  int unsigned position;
  int unsigned runs;
  logic        in_silence;
  logic [6:0]  peak;
  int          mismatches = 0;

  // log2 in Q(LOG_FRACTION_BITS): leading-one index, then one fraction bit per squaring
  function automatic longint log2_q(input int unsigned v);
    int unsigned     lead;
    longint unsigned mant;
    longint          acc;
    int              i;
    lead = 0;
    while (lead < 31 && (v >> (lead + 1)) != 0) lead++;
    mant = ({32'd0, v} << 30) >> lead;
    acc = longint'(lead);
    for (i = 0; i < LOG_FRACTION_BITS; i++) begin
      mant = (mant * mant) >> 30;
      acc = acc * 2;
      if (mant >= (64'd2 << 30)) begin
        mant = mant >> 1;
        acc = acc + 1;
      end
    end
    return acc;
  endfunction

  function automatic logic [6:0] pitch_of(input int unsigned run_total, input logic [3:0] k);
    longint one;
    longint rate;
    longint t;
    longint n;
    one = longint'(1) << LOG_FRACTION_BITS;
    rate = longint'((RATE_RATIO_LOG2_Q30 + (64'd1 << (29 - LOG_FRACTION_BITS)))
                    >> (30 - LOG_FRACTION_BITS));
    t = longint'(SEMITONES) * (log2_q(run_total) + rate - longint'(k) * one)
        + longint'(REF_NOTE) * one;
    n = t / one;  // truncates toward zero, negative notes wrap below
    return n[6:0];
  endfunction

  task automatic take_sample(input logic [6:0] s);
    midi_note_t due;
    if (s > peak) peak = s;
    if (s == 7'd0) begin
      in_silence = 1'b1;
    end else if (in_silence) begin
      runs++;
      in_silence = 1'b0;
    end
    position++;
    // also covers a window shortened below the current position
    if (position >= (32'd1 << window_log2)) begin
      if (runs > 1) begin
        due.note_number = pitch_of(runs, window_log2);
        due.velocity = VELOCITY_BASE + peak;
      end else begin
        due.note_number = NO_PITCH_NOTE;
        due.velocity = 7'd0;
      end
      due.channel = midi_channel;
      notes_due.push_back(due);
      position = 0;
      runs = 0;
      in_silence = 1'b1;
      peak = 7'd0;
    end
  endtask

  always @(posedge clk) begin
    midi_note_t got;
    midi_note_t want;
    if (rst) begin
      window_log2 = WINDOW_LOG2_RESET;
      midi_channel = MIDI_CHANNEL_RESET;
      position = 0;
      runs = 0;
      in_silence = 1'b1;
      peak = 7'd0;
      notes_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[17:0];
        if (notes_due.size() == 0) begin
          $error("note result with none expected: %h", m_tdata);
          mismatches++;
        end else begin
          want = notes_due.pop_front();
          if (got.note_number !== want.note_number) begin
            $error("note_number: expected %0d, actual %0d", want.note_number, got.note_number);
            mismatches++;
          end
          if (got.velocity !== want.velocity) begin
            $error("velocity: expected %0d, actual %0d", want.velocity, got.velocity);
            mismatches++;
          end
          if (got.channel !== want.channel) begin
            $error("channel: expected %0d, actual %0d", want.channel, got.channel);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) take_sample(s_tdata[6:0]);
      if (cfg_we) begin
        case (cfg_addr)
          REG_WINDOW_LOG2:  window_log2 = cfg_wdata;
          REG_MIDI_CHANNEL: midi_channel = cfg_wdata;
          default: ;
        endcase
      end
    end
    fail_count <= mismatches;
    notes_pending <= notes_due.size();
  end

endmodule

[sim/tb_run_count_pitch_to_midi_note.sv]
`timescale 1ns / 1ps
module tb_run_count_pitch_to_midi_note;
  import rcpm_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 64;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_SAMPLES = 640;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [23:0]           m_tdata;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [3:0]            cfg_wdata = '0;

  int note_failures;
  int notes_pending;
  int idle_cycles = 0;
  int zero_mix[5] = '{0, 20, 50, 80, 97};
  bit steady_feed  = 1'b0;
  bit steady_drain = 1'b0;
  bit hold_off_req = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  run_count_pitch_to_midi_note uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  rcpm_note_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (note_failures),
    .notes_pending (notes_pending)
  );

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [6:0] pick_sample(input int zero_pct);
    if ($urandom_range(0, 99) < zero_pct) return 7'd0;
    return 7'($urandom_range(1, 127));
  endfunction

  task automatic send_sample(input logic [6:0] v);
    int gap;
    gap = steady_feed ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, v};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic set_config(input logic [3:0] k, input logic [3:0] ch);
    cfg_we <= 1'b1;
    cfg_addr <= REG_WINDOW_LOG2;
    cfg_wdata <= k;
    @(posedge clk);
    cfg_addr <= REG_MIDI_CHANNEL;
    cfg_wdata <= ch;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // drain every expected note, then let a trailing window-end computation settle
  task automatic finish_phase();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (notes_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side
  initial begin : drain
    int gap;
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      if (hold_off_req && !hold_done) begin
        gap = HOLD_CYCLES;
        hold_done = 1'b1;
      end else if (steady_drain) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 10);
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin
    int i;
    int sent;
    int count;
    int zero_pct;
    logic [3:0] k;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings: a partial window with alternating silence
    steady_feed = 1'b1;
    for (i = 0; i < 24; i++) send_sample(i[0] ? pick_sample(0) : 7'd0);
    finish_phase();
    steady_feed = 1'b0;

    // one-sample windows: the first sample closes the leftover window, then no pitch
    set_config(4'd0, 4'd15);
    send_sample(7'd0);
    send_sample(7'd127);
    for (i = 0; i < 7; i++) send_sample(7'd1 << i);
    send_sample(7'd85);
    send_sample(7'd42);
    finish_phase();

    // four runs with a peak that wraps the velocity, then a partial window
    set_config(4'd3, 4'd5);
    send_sample(7'd1);
    send_sample(7'd0);
    send_sample(7'd127);
    send_sample(7'd0);
    send_sample(7'd85);
    send_sample(7'd0);
    send_sample(7'd42);
    send_sample(7'd0);
    send_sample(7'd127);
    send_sample(7'd0);
    send_sample(7'd127);
    finish_phase();

    // shorten the window below the current position: next sample closes it
    set_config(4'd1, 4'd5);
    send_sample(7'd0);
    finish_phase();

    // long output stall while samples keep coming
    set_config(4'd1, 4'd3);
    steady_feed = 1'b1;
    hold_off_req = 1'b1;
    for (i = 0; i < 16; i++) send_sample(pick_sample(30));
    finish_phase();

    sent = 0;
    while (sent < RANDOM_SAMPLES) begin
      k = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 4)) : 4'($urandom_range(5, 7));
      set_config(k, 4'($urandom_range(0, 15)));
      zero_pct = zero_mix[$urandom_range(0, 4)];
      // a few extra samples leave a partial window for the next setting
      count = (1 << k) * $urandom_range(1, 3) + $urandom_range(0, 3);
      steady_feed = ($urandom_range(0, 3) == 0);
      steady_drain = ($urandom_range(0, 3) == 0);
      for (i = 0; i < count; i++) send_sample(pick_sample(zero_pct));
      sent += count;
      finish_phase();
    end
    steady_drain = 1'b0;

    if (note_failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
